[hw/rtl/asdp_pkg.sv]
// shared types, character codes and month name table for the time string parser
package asdp_pkg;

	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned VAL_W      = 14;
	localparam int unsigned MON_W      = 4;
	localparam int unsigned LEN_W      = 3;
	localparam int unsigned FIELD_W    = 3;
	localparam int unsigned TOK_DEPTH  = 4;
	localparam int unsigned MONTHS     = 12;
	localparam int unsigned TDATA_W    = 80;
	localparam int unsigned TUSER_W    = 3;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	localparam logic [LEN_W-1:0] TOK_FULL  = 3'd4;
	localparam logic [LEN_W-1:0] MON_LEN   = 3'd3;

	localparam logic signed [VAL_W:0] YEAR_BASE = 15'sd1900;

	// field order inside one string
	localparam logic [FIELD_W-1:0] FLD_WEEKDAY = 3'd0;
	localparam logic [FIELD_W-1:0] FLD_MONTH   = 3'd1;
	localparam logic [FIELD_W-1:0] FLD_DAY     = 3'd2;
	localparam logic [FIELD_W-1:0] FLD_HOUR    = 3'd3;
	localparam logic [FIELD_W-1:0] FLD_MINUTE  = 3'd4;
	localparam logic [FIELD_W-1:0] FLD_SECOND  = 3'd5;
	localparam logic [FIELD_W-1:0] FLD_YEAR    = 3'd6;
	localparam logic [FIELD_W-1:0] FLD_DONE    = 3'd7;

	typedef logic [CHAR_W-1:0] char_t;

	// decoded view of the token currently held
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [MON_W-1:0] month;
		logic             month_hit;
		logic             epoch;
	} tok_info_t;

	// three-letter month names, first letter in the high byte
	function automatic logic [3*CHAR_W-1:0] month_name(input logic [MON_W-1:0] idx);
		logic [3*CHAR_W-1:0] n;
		case (idx)
			4'd0:    n = "Jan";
			4'd1:    n = "Feb";
			4'd2:    n = "Mar";
			4'd3:    n = "Apr";
			4'd4:    n = "May";
			4'd5:    n = "Jun";
			4'd6:    n = "Jul";
			4'd7:    n = "Aug";
			4'd8:    n = "Sep";
			4'd9:    n = "Oct";
			4'd10:   n = "Nov";
			4'd11:   n = "Dec";
			default: n = '0;
		endcase
		return n;
	endfunction

endpackage

[hw/rtl/asdp_tok_dec.sv]
// decodes the held token: decimal value, month name match and epoch year check
module asdp_tok_dec import asdp_pkg::*; (
	input  char_t            chars [TOK_DEPTH],
	input  logic [LEN_W-1:0] len,
	output tok_info_t        info
);

	logic [VAL_W-1:0] val;
	logic             skipping;
	logic             active;
	logic [MON_W-1:0] mon;
	logic             hit;
	logic [3*CHAR_W-1:0] name3;

	// skip leading control whitespace, then take digits up to the first non-digit
	always_comb begin
		val      = '0;
		skipping = 1'b1;
		active   = 1'b1;
		for (int i = 0; i < TOK_DEPTH; i++) begin
			if (LEN_W'(i) < len) begin
				if (skipping && chars[i] >= CH_TAB && chars[i] <= CH_CR) begin
					skipping = 1'b1;
				end else begin
					skipping = 1'b0;
					if (active && chars[i] >= CH_ZERO && chars[i] <= CH_NINE) begin
						val = VAL_W'(val * VAL_W'(10)) + VAL_W'(chars[i] - CH_ZERO);
					end else begin
						active = 1'b0;
					end
				end
			end
		end
	end

	assign name3 = {chars[0], chars[1], chars[2]};

	always_comb begin
		mon = '0;
		hit = 1'b0;
		if (len == MON_LEN) begin
			for (int m = MONTHS - 1; m >= 0; m--) begin
				if (name3 == month_name(MON_W'(m))) begin
					mon = MON_W'(m);
					hit = 1'b1;
				end
			end
		end
	end

	assign info.value     = val;
	assign info.month     = mon;
	assign info.month_hit = hit;
	assign info.epoch     = (len == TOK_FULL) && ({chars[0], chars[1], chars[2], chars[3]} == "1970");

endmodule

[hw/rtl/asctime_datetime_string_parser_unit.sv]
// top level: character-serial parser for "Www Mmm dd hh:mm:ss yyyy" time strings
// a NUL passes through the input register and then the result register before it shows on m_tvalid
// throughput: one character per cycle, no bubbles while the result side keeps up
// the token and field state sits behind the input register and advances once per character
// a NUL stalls only when the result register is full and not being drained
// reset (arst_n low, asynchronous) clears all string state and both valid flags
module asctime_datetime_string_parser_unit import asdp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [CHAR_W-1:0]  s_tdata,  // [7:0] character
	output logic               m_tvalid,
	input  logic               m_tready,
	// [13:0] year_since_1900, [17:14] month_index, [31:18] day_of_month,
	// [45:32] hour_value, [59:46] minute_value, [73:60] second_value, [79:74] zero
	output logic [TDATA_W-1:0] m_tdata,
	output logic [TUSER_W-1:0] m_tuser   // [0] month_known, [1] complete, [2] accepted
);

	// input register
	logic             valid_s1;
	char_t            char_s1;

	// string state
	char_t            chars_q [TOK_DEPTH];
	logic [LEN_W-1:0]   len_q;
	logic [FIELD_W-1:0] field_q;
	logic [MON_W-1:0]   month_q;
	logic               month_seen_q;
	logic [VAL_W-1:0]   day_q;
	logic [VAL_W-1:0]   hour_q;
	logic [VAL_W-1:0]   minute_q;
	logic [VAL_W-1:0]   second_q;
	logic [VAL_W-1:0]   year_q;
	logic               epoch_q;

	// result register
	logic               out_valid_q;
	logic [TDATA_W-1:0] out_data_q;
	logic [TUSER_W-1:0] out_user_q;

	// next-state values after the current character
	logic [MON_W-1:0]   nx_month;
	logic               nx_month_seen;
	logic [VAL_W-1:0]   nx_day;
	logic [VAL_W-1:0]   nx_hour;
	logic [VAL_W-1:0]   nx_minute;
	logic [VAL_W-1:0]   nx_second;
	logic [VAL_W-1:0]   nx_year;
	logic               nx_epoch;
	logic [FIELD_W-1:0] nx_field;

	tok_info_t          tok;
	logic               is_nul;
	logic               ends_token;
	logic               out_free;
	logic               fire;
	logic               done;
	logic signed [VAL_W:0] year_off;
	logic [VAL_W-1:0]   year_out;
	logic [MON_W-1:0]   month_out;

	asdp_tok_dec u_tok_dec (
		.chars (chars_q),
		.len   (len_q),
		.info  (tok)
	);

	assign is_nul     = (char_s1 == CH_NUL);
	// a separator or a full token closes the current token; the character is then dropped
	assign ends_token = (char_s1 == CH_SPACE) || (char_s1 == CH_COLON) || is_nul
		|| (len_q >= TOK_FULL);
	assign out_free   = !out_valid_q || m_tready;
	// only a NUL needs room in the result register
	assign fire       = valid_s1 && (!is_nul || out_free);
	assign s_tready   = !valid_s1 || fire;

	// apply the closed token to the field it belongs to
	always_comb begin
		nx_month      = month_q;
		nx_month_seen = month_seen_q;
		nx_day        = day_q;
		nx_hour       = hour_q;
		nx_minute     = minute_q;
		nx_second     = second_q;
		nx_year       = year_q;
		nx_epoch      = epoch_q;
		nx_field      = field_q;
		if (ends_token) begin
			case (field_q)
				FLD_MONTH: begin
					nx_month      = tok.month;
					nx_month_seen = tok.month_hit;
				end
				FLD_DAY:    nx_day    = tok.value;
				FLD_HOUR:   nx_hour   = tok.value;
				FLD_MINUTE: nx_minute = tok.value;
				FLD_SECOND: nx_second = tok.value;
				FLD_YEAR: begin
					nx_year  = tok.value;
					nx_epoch = tok.epoch;
				end
				default: ;
			endcase
			// field count saturates once the year is past
			if (field_q != FLD_DONE) begin
				nx_field = field_q + FIELD_W'(1);
			end
		end
	end

	// result fields as seen right after the NUL closes its token
	assign done      = (nx_field == FLD_DONE);
	assign year_off  = $signed({1'b0, nx_year}) - YEAR_BASE;
	assign year_out  = done ? year_off[VAL_W-1:0] : '0;
	assign month_out = nx_month_seen ? nx_month : '0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	// string state: a NUL starts a fresh string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOK_DEPTH; i++) begin
				chars_q[i] <= '0;
			end
			len_q        <= '0;
			field_q      <= FLD_WEEKDAY;
			month_q      <= '0;
			month_seen_q <= 1'b0;
			day_q        <= '0;
			hour_q       <= '0;
			minute_q     <= '0;
			second_q     <= '0;
			year_q       <= '0;
			epoch_q      <= 1'b0;
		end else if (fire) begin
			if (is_nul) begin
				for (int i = 0; i < TOK_DEPTH; i++) begin
					chars_q[i] <= '0;
				end
				len_q        <= '0;
				field_q      <= FLD_WEEKDAY;
				month_q      <= '0;
				month_seen_q <= 1'b0;
				day_q        <= '0;
				hour_q       <= '0;
				minute_q     <= '0;
				second_q     <= '0;
				year_q       <= '0;
				epoch_q      <= 1'b0;
			end else begin
				month_q      <= nx_month;
				month_seen_q <= nx_month_seen;
				day_q        <= nx_day;
				hour_q       <= nx_hour;
				minute_q     <= nx_minute;
				second_q     <= nx_second;
				year_q       <= nx_year;
				epoch_q      <= nx_epoch;
				field_q      <= nx_field;
				if (ends_token) begin
					len_q <= '0;
				end else begin
					// stale characters past len_q are never looked at
					chars_q[len_q[1:0]] <= char_s1;
					len_q               <= len_q + LEN_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && is_nul) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_nul) begin
			out_data_q <= {6'b0, nx_second, nx_minute, nx_hour, nx_day, month_out, year_out};
			out_user_q <= {!nx_epoch, done, nx_month_seen};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
